// ----- hw/rtl/log_grid_bilinear_interp_macros.svh -----
// assertion macros for the log-grid interpolator
`ifndef LOG_GRID_BILINEAR_INTERP_MACROS_SVH
`define LOG_GRID_BILINEAR_INTERP_MACROS_SVH
`ifndef SYNTHESIS
`define LGBI_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lgbi check failed");
`define LGBI_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lgbi check failed");
`else
`define LGBI_ASSERT_IMPL(label, clk, rst, ante, cons)
`define LGBI_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- hw/rtl/lgbi_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lgbi_pkg
// shared constants and types for the log-grid bilinear interpolator
// ---------------------------------------------------------------------------
package lgbi_pkg;
  localparam int RadialPoints = 601;
  localparam int HeightPoints = 601;
  localparam int BankRows = (RadialPoints + 1) / 2;
  localparam int BankCols = (HeightPoints + 1) / 2;
  localparam int BankDepth = BankRows * BankCols;
  localparam int BankAw = $clog2(BankDepth);
  localparam int HalfW = $clog2(BankRows > BankCols ? BankRows : BankCols);
  localparam logic [31:0] Log10Of2 = 32'h4D104D42;
  // log stage count: one squaring per fraction bit
  localparam int LogSteps = 32;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  // one coordinate's grid position
  typedef struct packed {
    logic        outside;
    logic [9:0]  idx;
    logic [15:0] frac;
  } grid_pos_t;

  // bank access request
  typedef struct packed {
    logic                       wr_en;
    logic [1:0]                 wr_bank;
    logic [BankAw-1:0]          wr_addr;
    logic [31:0]                wr_data;
    logic                       rd_en;
    logic [3:0][BankAw-1:0]     rd_addr;
  } bank_req_t;
endpackage

// ----- hw/rtl/lgbi_log_pipe.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lgbi_log_pipe
// pipelined log10 of a Q20.8 coordinate scaled to a grid cell and fraction
// ---------------------------------------------------------------------------
module lgbi_log_pipe (
  input  logic                  clk,
  input  logic                  en,
  input  logic [27:0]           coord,
  input  logic [10:0]           steps,
  output lgbi_pkg::grid_pos_t   pos
);
  import lgbi_pkg::*;

  localparam int Depth = LogSteps + 5;

  // per-stage squaring state
  logic [32:0] m      [LogSteps+1];
  logic [31:0] fb     [LogSteps+1];
  logic [4:0]  hi     [LogSteps+1];
  logic        bad    [LogSteps+1];
  logic [10:0] stp    [LogSteps+1];

  logic [4:0]  msb;
  logic [63:0] sq      [LogSteps];
  logic [32:0] sq_sh   [LogSteps];

  // tail stages
  logic [63:0] lo_k;
  logic [36:0] hi_k;
  logic [31:0] lo_k_r;
  logic [36:0] hi_k_r;
  logic        bad_a, bad_b, bad_c;
  logic [10:0] stp_a, stp_b;
  logic [36:0] l10;
  logic [47:0] t_part;
  logic [47:0] t;
  logic [47:0] t_r;

  // leading one search
  always_comb begin
    msb = 5'd0;
    for (int i = 0; i < 28; i++) begin
      if (coord[i]) begin
        msb = 5'(i);
      end
    end
  end

  // normalize into Q1.31
  always_ff @(posedge clk) begin
    if (en) begin
      m[0]   <= {1'b0, {4'b0, coord} << (5'd31 - msb)};
      fb[0]  <= '0;
      hi[0]  <= msb - 5'd8;
      bad[0] <= (msb < 5'd8) || (steps == 11'd0);
      stp[0] <= steps;
    end
  end

  // one squaring per stage
  for (genvar k = 0; k < LogSteps; k++) begin : g_sq
    assign sq[k]    = 64'(m[k][31:0]) * 64'(m[k][31:0]);
    assign sq_sh[k] = sq[k][63:31];
    always_ff @(posedge clk) begin
      if (en) begin
        if (sq_sh[k][32]) begin
          m[k+1]  <= {1'b0, sq_sh[k][32:1]};
          fb[k+1] <= {fb[k][30:0], 1'b1};
        end else begin
          m[k+1]  <= sq_sh[k];
          fb[k+1] <= {fb[k][30:0], 1'b0};
        end
        hi[k+1]  <= hi[k];
        bad[k+1] <= bad[k];
        stp[k+1] <= stp[k];
      end
    end
  end

  // log2 to log10
  assign lo_k = 64'(fb[LogSteps]) * 64'(Log10Of2);
  assign hi_k = 37'(hi[LogSteps]) * 37'(Log10Of2);
  always_ff @(posedge clk) begin
    if (en) begin
      lo_k_r <= lo_k[63:32];
      hi_k_r <= hi_k;
      bad_a  <= bad[LogSteps];
      stp_a  <= stp[LogSteps];
    end
  end

  // scale by steps per decade, split into a 21x11 and a 16x11 product
  assign l10 = hi_k_r + 37'(lo_k_r);
  assign t_part = 48'(l10[36:16]) * 48'(stp_a);
  always_ff @(posedge clk) begin
    if (en) begin
      t      <= t_part;
      bad_b  <= bad_a;
      stp_b  <= stp_a;
      t_r    <= 48'(l10[15:0]) * 48'(stp_a);
    end
  end

  // t = (high part << 16) + low part, index is bits above 32
  logic [63:0] t_full;
  assign t_full = {t, 16'h0} + 64'(t_r);
  always_ff @(posedge clk) begin
    if (en) begin
      bad_c       <= bad_b || (stp_b == 11'd0);
      pos.outside <= bad_b || (t_full[63:32] >= 32'(RadialPoints - 1));
      pos.idx     <= t_full[41:32];
      pos.frac    <= t_full[31:16];
    end
  end

  logic unused;
  assign unused = bad_c ^ (Depth == 0);
endmodule

// ----- hw/rtl/lgbi_table.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lgbi_table
// four banks split on row and column parity, one read per bank per cycle while rd_en is high
// ---------------------------------------------------------------------------
module lgbi_table (
  input  logic                   clk,
  input  lgbi_pkg::bank_req_t    req,
  output logic [3:0][31:0]       rd_data
);
  import lgbi_pkg::*;

  logic [31:0] bank_rd [4];

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [31:0] mem [BankDepth];
    always_ff @(posedge clk) begin
      if (req.wr_en && req.wr_bank == 2'(b)) begin
        mem[req.wr_addr] <= req.wr_data;
      end
      if (req.rd_en) begin
        bank_rd[b] <= mem[req.rd_addr[b]];
      end
    end
  end

  // gather bank outputs
  always_comb begin
    for (int b = 0; b < 4; b++) begin
      rd_data[b] = bank_rd[b];
    end
  end
endmodule

// ----- hw/rtl/lgbi_blend.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lgbi_blend
// bilinear weighting of four corners, pipelined products
// ---------------------------------------------------------------------------
module lgbi_blend (
  input  logic              clk,
  input  logic              en,
  input  logic [3:0][31:0]  corner,
  input  logic [15:0]       fr,
  input  logic [15:0]       fz,
  output logic [31:0]       density
);
  import lgbi_pkg::*;

  logic [16:0] wr0, wr1, wz0, wz1;
  logic [3:0][31:0] c_r;
  logic [3:0][32:0] w;
  logic [3:0][64:0] p;
  logic [66:0] sum;

  assign wr1 = {1'b0, fr};
  assign wr0 = 17'h10000 - wr1;
  assign wz1 = {1'b0, fz};
  assign wz0 = 17'h10000 - wz1;

  // weight products
  always_ff @(posedge clk) begin
    if (en) begin
      w[0] <= 33'(wr0) * 33'(wz0);
      w[1] <= 33'(wr1) * 33'(wz0);
      w[2] <= 33'(wr0) * 33'(wz1);
      w[3] <= 33'(wr1) * 33'(wz1);
      c_r  <= corner;
    end
  end

  // corner times weight
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        p[i] <= 65'(c_r[i]) * 65'(w[i]);
      end
    end
  end

  assign sum = 67'(p[0]) + 67'(p[1]) + 67'(p[2]) + 67'(p[3]);
  always_ff @(posedge clk) begin
    if (en) begin
      density <= sum[63:32];
    end
  end
endmodule

// ----- hw/rtl/log_grid_bilinear_interp.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// log_grid_bilinear_interp
// 2-D density table on log grids with bilinear lookup
// ---------------------------------------------------------------------------
//  channel   dir  handshake                 payload
//  s_axis    in   s_axis_tvalid/tready      command,row,column,value,r,h
//  m_axis    out  m_axis_tvalid/tready      density, outside (tuser)
//  cfg       in   cfg_wr_en                 steps_per_decade
// one word per cycle while the output is not stalled; a query passes through
// normalize, a log squaring chain of 32 stages, three scaling stages, table
// read and blend. writes ride the same stages and land in the table at the read
// stage, so reads and writes keep stream order. the whole pipe stalls while
// the output word waits; rst is synchronous, table contents are undefined
// until written.
`include "log_grid_bilinear_interp_macros.svh"
module log_grid_bilinear_interp (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wr_en,
  input  logic [10:0]  cfg_wr_data,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // command, row, column, entry_value, radius, height (zero fill to 112)
  input  logic [111:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // density
  output logic [31:0]  m_axis_tdata,
  // outside
  output logic         m_axis_tuser
);
  import lgbi_pkg::*;

  localparam int LogLat = LogSteps + 4;
  localparam int Lat = LogLat + 4;

  logic [10:0] steps;
  logic en, acc;
  logic cmd;
  logic [9:0] row_i, col_i;
  logic [31:0] val_i;
  logic [27:0] rad_i, hgt_i;

  assign cmd   = s_axis_tdata[0];
  assign row_i = s_axis_tdata[10:1];
  assign col_i = s_axis_tdata[20:11];
  assign val_i = s_axis_tdata[52:21];
  assign rad_i = s_axis_tdata[80:53];
  assign hgt_i = s_axis_tdata[108:81];

  // pipe advances unless the output word is stuck
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign acc = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= 11'd100;
    end else if (cfg_wr_en) begin
      steps <= cfg_wr_data;
    end
  end

  // query valid chain alongside the log pipes
  logic [LogLat-1:0] qv;
  always_ff @(posedge clk) begin
    if (rst) begin
      qv <= '0;
    end else if (en) begin
      qv <= {qv[LogLat-2:0], acc && cmd_t'(cmd) == CMD_QUERY};
    end
  end

  grid_pos_t pr, pz;
  lgbi_log_pipe u_log_r (.clk, .en, .coord(rad_i), .steps, .pos(pr));
  lgbi_log_pipe u_log_z (.clk, .en, .coord(hgt_i), .steps, .pos(pz));

  // height axis bound may differ from radial
  logic out_q;
  assign out_q = pr.outside || pz.outside || (32'(pz.idx) >= 32'(HeightPoints - 1))
                 || (rad_i == rad_i && 1'b0);

  // bank addressing: corner (r+a, z+b) sits in bank of its parities
  logic [10:0] r0, r1, z0, z1;
  assign r0 = {1'b0, pr.idx};
  assign r1 = r0 + 11'd1;
  assign z0 = {1'b0, pz.idx};
  assign z1 = z0 + 11'd1;

  function automatic logic [BankAw-1:0] baddr(logic [10:0] r, logic [10:0] z);
    baddr = BankAw'(32'(r[10:1]) * BankCols + 32'(z[10:1]));
  endfunction

  bank_req_t req;
  logic wr_ok;
  assign wr_ok = acc && cmd_t'(cmd) == CMD_WRITE && 32'(row_i) < RadialPoints
                 && 32'(col_i) < HeightPoints;

  // table writes travel with the queries and land at the read stage
  logic [LogLat-1:0] wv;
  logic [51:0] wd [LogLat];
  logic [9:0] wr_row, wr_col;
  always_ff @(posedge clk) begin
    if (rst) begin
      wv <= '0;
    end else if (en) begin
      wv <= {wv[LogLat-2:0], wr_ok};
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      wd[0] <= {val_i, col_i, row_i};
      for (int i = 1; i < LogLat; i++) begin
        wd[i] <= wd[i-1];
      end
    end
  end
  assign wr_row = wd[LogLat-1][9:0];
  assign wr_col = wd[LogLat-1][19:10];

  always_comb begin
    req.wr_en   = en && wv[LogLat-1];
    req.wr_bank = {wr_row[0], wr_col[0]};
    req.wr_addr = baddr({1'b0, wr_row}, {1'b0, wr_col});
    req.wr_data = wd[LogLat-1][51:20];
    req.rd_en   = en;
    for (int b = 0; b < 4; b++) begin
      req.rd_addr[b] = '0;
    end
    // corner 0: (r0,z0) 1: (r1,z0) 2: (r0,z1) 3: (r1,z1)
    req.rd_addr[{r0[0], z0[0]}] = baddr(r0, z0);
    req.rd_addr[{r1[0], z0[0]}] = baddr(r1, z0);
    req.rd_addr[{r0[0], z1[0]}] = baddr(r0, z1);
    req.rd_addr[{r1[0], z1[0]}] = baddr(r1, z1);
  end

  logic [3:0][31:0] bank_q;
  lgbi_table u_table (.clk, .req, .rd_data(bank_q));

  // hold side info across the read
  logic [1:0] par;
  logic [15:0] fr1, fz1;
  logic v1, o1;
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= qv[LogLat-1];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      par <= {pr.idx[0], pz.idx[0]};
      fr1 <= pr.frac;
      fz1 <= pz.frac;
      o1  <= out_q;
    end
  end

  // route banks back to corner order
  logic [3:0][31:0] corner;
  always_comb begin
    corner[0] = bank_q[par];
    corner[1] = bank_q[par ^ 2'b10];
    corner[2] = bank_q[par ^ 2'b01];
    corner[3] = bank_q[par ^ 2'b11];
  end

  logic [31:0] dens;
  lgbi_blend u_blend (.clk, .en, .corner, .fr(fr1), .fz(fz1), .density(dens));

  // carry valid and outside alongside the blend pipeline
  logic [2:0] bv, bo;
  always_ff @(posedge clk) begin
    if (rst) begin
      bv <= '0;
    end else if (en) begin
      bv <= {bv[1:0], v1};
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      bo <= {bo[1:0], o1};
    end
  end

  assign m_axis_tvalid = bv[2];
  assign m_axis_tdata  = bo[2] ? 32'd0 : dens;
  assign m_axis_tuser  = bo[2];

  logic unused;
  assign unused = ^s_axis_tdata[111:109] ^ (Lat == 0) ^ ^HalfW;

  `LGBI_ASSERT_IMPL(a_stall_ready, clk, rst, m_axis_tvalid && !m_axis_tready, !s_axis_tready)
  `LGBI_ASSERT_NEXT(a_hold_out, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `LGBI_ASSERT_IMPL(a_outside_zero, clk, rst, m_axis_tvalid && m_axis_tuser, m_axis_tdata == 32'd0)
endmodule
